[hdl/vsd_pkg.sv]
// vsd_pkg: shared constants, types and helpers of the varint stream decoder.
// Depends on nothing; used by the interfaces, the cell and the top level.
package vsd_pkg;

  localparam int LANE_MAX        = 8;   // widest input word, in bytes
  localparam int MAX_VALUE_BYTES = 5;   // longest encoding of a 32-bit value
  localparam int DATA_W          = 64;
  localparam int BC_W            = 4;
  localparam int VALUE_W         = 32;
  localparam int TOTAL_W         = 35;
  localparam int CNT_W           = 4;   // holds 0..LANE_MAX
  localparam int LANE_W          = 3;   // lane index 0..LANE_MAX-1
  localparam int PB_W            = 3;   // bytes gathered of an open value

  localparam logic [VALUE_W-1:0] VC_RESET = 32'd1;
  localparam logic [PB_W-1:0]    LAST_SLOT = PB_W'(MAX_VALUE_BYTES - 1);

  // State handed from one lane cell to the next within a word.
  typedef struct packed {
    logic [VALUE_W-1:0] pv;       // bits gathered of the open value
    logic [PB_W-1:0]    pb;       // bytes gathered of the open value
    logic [CNT_W-1:0]   cnt;      // values finished so far in this word
    logic               seen;     // a sequence ended earlier in this word
    logic [LANE_W-1:0]  last;     // lane of that sequence end
    logic [CNT_W-1:0]   seq_cnt;  // value count at that sequence end
  } carry_t;

  // One decoded result held in a lane cell.
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               sequence_end;
    logic [TOTAL_W-1:0] bytes_used;
    logic               overlong;
  } lane_res_t;

  // True when d is a whole multiple of v (d below 8, v from 1 to 8).
  function automatic logic is_mult(logic [2:0] d, logic [3:0] v);
    logic r;
    r = 1'b0;
    for (int m = 0; m < 8; m++) begin
      if (7'(m) * {3'b000, v} == {4'b0000, d}) begin
        r = 1'b1;
      end
    end
    return r;
  endfunction

endpackage

[hdl/vsd_in_if.sv]
// vsd_in_if: input word channel of the varint stream decoder.
// Depends on vsd_pkg for field widths.
interface vsd_in_if;
  logic                         valid;
  logic                         ready;
  logic [vsd_pkg::DATA_W-1:0]   data_word;
  logic [vsd_pkg::BC_W-1:0]     byte_count;

  modport source (output valid, output data_word, output byte_count, input ready);
  modport sink   (input valid, input data_word, input byte_count, output ready);
endinterface

[hdl/vsd_out_if.sv]
// vsd_out_if: result channel of the varint stream decoder.
// Depends on vsd_pkg for field widths.
interface vsd_out_if;
  logic                         valid;
  logic                         ready;
  logic [vsd_pkg::VALUE_W-1:0]  value;
  logic                         sequence_end;
  logic [vsd_pkg::TOTAL_W-1:0]  bytes_used;
  logic                         overlong;
  logic                         item_end;

  modport source (output valid, output value, output sequence_end, output bytes_used,
                  output overlong, output item_end, input ready);
  modport sink   (input valid, input value, input sequence_end, input bytes_used,
                  input overlong, input item_end, output ready);
endinterface

[hdl/varint_stream_decoder.sv]
// varint_stream_decoder: top level; LEB128 decoder for unsigned 32-bit values.
// Depends on vsd_pkg, vsd_in_if, vsd_out_if and vsd_cell.
//
// Usage:
//   in_chan  (valid/ready) takes one word of up to LANE_BYTES encoded bytes,
//            first byte in bits 7..0, byte_count valid bytes (clamped).
//   out_chan (valid/ready) gives one decoded value per transfer, in byte
//            order; item_end marks the last value caused by an input word,
//            sequence_end the value_count-th value, with the sequence's byte
//            total in bytes_used.
//   cfg_we/cfg_data write value_count (reset 1); write only while idle.
// Structure: a row of LANE_BYTES lane cells; the open value and sequence
//   position ripple through it in the accept cycle, each cell keeps its result.
// Flow: the first value of a word is shown in the cycle after the word is
//   accepted. The values that a word ends leave one by one through the single result
//   port; a new word is taken in the cycle the last pending value leaves, so words
//   that end at most one value flow at one per cycle while out_chan.ready is high.
// Reset: clears the open value, the sequence counters and all pending
//   results, and sets value_count to 1.
// Stall: while out_chan.ready is low, hold the pending value and in_chan.ready.
module varint_stream_decoder #(
  parameter int LANE_BYTES = vsd_pkg::LANE_MAX
) (
  input  logic                        clk,
  input  logic                        rst_n,
  vsd_in_if.sink                      in_chan,
  vsd_out_if.source                   out_chan,
  input  logic                        cfg_we,
  input  logic [vsd_pkg::VALUE_W-1:0] cfg_data
);

  // Configuration and carried state
  logic [vsd_pkg::VALUE_W-1:0] vc_r;
  logic [vsd_pkg::VALUE_W-1:0] pv_r;
  logic [vsd_pkg::PB_W-1:0]    pb_r;
  logic [vsd_pkg::VALUE_W-1:0] vd_r;     // values done in this sequence
  logic [vsd_pkg::TOTAL_W-1:0] base_r;   // bytes consumed in this sequence
  logic [vsd_pkg::VALUE_W-1:0] vd_nxt;
  logic [vsd_pkg::TOTAL_W-1:0] base_nxt;

  logic                        in_fire;
  logic                        out_fire;
  logic [vsd_pkg::BC_W-1:0]    nbytes;
  logic [vsd_pkg::VALUE_W-1:0] rem;
  logic                        rem_small;
  logic                        vc_small;
  logic [vsd_pkg::CNT_W-1:0]   span;
  logic [vsd_pkg::LANE_MAX:0]  hit_vec;

  vsd_pkg::carry_t             chain [0:LANE_BYTES];
  vsd_pkg::lane_res_t          res   [0:LANE_BYTES-1];
  logic [LANE_BYTES-1:0]       mask;
  logic [LANE_BYTES-1:0]       pick;
  logic [LANE_BYTES-1:0]       active;
  vsd_pkg::lane_res_t          sel;

  assign in_fire  = in_chan.valid & in_chan.ready;
  assign out_fire = out_chan.valid & out_chan.ready;

  // Clamp the byte count to the lanes present
  assign nbytes = (in_chan.byte_count > vsd_pkg::BC_W'(LANE_BYTES)) ?
                  vsd_pkg::BC_W'(LANE_BYTES) : in_chan.byte_count;

  // Which running value counts in this word close a sequence: the first at
  // rem, then every value_count values after it.
  always_comb begin
    rem       = vc_r - vd_r;
    rem_small = (rem != '0) && (rem <= vsd_pkg::VALUE_W'(LANE_BYTES));
    vc_small  = (vc_r != '0) && (vc_r <= vsd_pkg::VALUE_W'(LANE_BYTES));
    for (int j = 0; j <= vsd_pkg::LANE_MAX; j++) begin
      span       = vsd_pkg::CNT_W'(j) - rem[vsd_pkg::CNT_W-1:0];
      hit_vec[j] = rem_small && (vsd_pkg::CNT_W'(j) >= rem[vsd_pkg::CNT_W-1:0]) &&
                   ((span == '0) || (vc_small && vsd_pkg::is_mult(span[2:0], vc_r[3:0])));
    end
  end

  // Head of the chain: the value left open by the previous word
  always_comb begin
    chain[0]         = '0;
    chain[0].pv      = pv_r;
    chain[0].pb      = pb_r;
  end

  for (genvar k = 0; k < LANE_BYTES; k++) begin : g_lane
    assign active[k] = nbytes > vsd_pkg::BC_W'(k);

    vsd_cell #(
      .LANE (k)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .byte_in (in_chan.data_word[8*k +: 8]),
      .active  (active[k]),
      .carry_i (chain[k]),
      .carry_o (chain[k+1]),
      .hit_vec (hit_vec),
      .base    (base_r),
      .load    (in_fire),
      .clear   (out_fire & pick[k]),
      .valid_o (mask[k]),
      .res_o   (res[k])
    );
  end

  // Sequence counters after the word
  always_comb begin
    if (chain[LANE_BYTES].seen) begin
      vd_nxt   = vsd_pkg::VALUE_W'(chain[LANE_BYTES].cnt - chain[LANE_BYTES].seq_cnt);
      base_nxt = vsd_pkg::TOTAL_W'(nbytes) - vsd_pkg::TOTAL_W'(chain[LANE_BYTES].last)
                 - vsd_pkg::TOTAL_W'(1);
    end else begin
      vd_nxt   = vd_r + vsd_pkg::VALUE_W'(chain[LANE_BYTES].cnt);
      base_nxt = base_r + vsd_pkg::TOTAL_W'(nbytes);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r   <= vsd_pkg::VC_RESET;
      pv_r   <= '0;
      pb_r   <= '0;
      vd_r   <= '0;
      base_r <= '0;
    end else begin
      if (cfg_we) begin
        vc_r <= cfg_data;
      end
      if (in_fire) begin
        pv_r   <= chain[LANE_BYTES].pv;
        pb_r   <= chain[LANE_BYTES].pb;
        vd_r   <= vd_nxt;
        base_r <= base_nxt;
      end
    end
  end

  // Drain: lowest pending lane goes out first
  assign pick = mask & (~mask + LANE_BYTES'(1));

  always_comb begin
    sel = '0;
    for (int k = 0; k < LANE_BYTES; k++) begin
      if (pick[k]) begin
        sel = res[k];
      end
    end
  end

  assign out_chan.valid        = |mask;
  assign out_chan.value        = sel.value;
  assign out_chan.sequence_end = sel.sequence_end;
  assign out_chan.bytes_used   = sel.bytes_used;
  assign out_chan.overlong     = sel.overlong;
  assign out_chan.item_end     = (mask & ~pick) == '0;

  // Take a new word once the held one is empty or leaves this cycle
  assign in_chan.ready = (mask & ~(out_fire ? pick : '0)) == '0;

endmodule

[hdl/vsd_cell.sv]
// vsd_cell: one byte lane of the decoder chain; decodes its byte against the
// carry from the lane below and holds its own result. Depends on vsd_pkg.
module vsd_cell #(
  parameter int LANE = 0
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [7:0]                  byte_in,
  input  logic                        active,
  input  vsd_pkg::carry_t             carry_i,
  output vsd_pkg::carry_t             carry_o,
  input  logic [vsd_pkg::LANE_MAX:0]  hit_vec,
  input  logic [vsd_pkg::TOTAL_W-1:0] base,
  input  logic                        load,
  input  logic                        clear,
  output logic                        valid_o,
  output vsd_pkg::lane_res_t          res_o
);

  logic [6:0]                  grp;
  logic                        more;
  logic                        last_slot;
  logic [4:0]                  sh;
  logic [vsd_pkg::VALUE_W-1:0] val;
  logic                        over;
  logic                        ends;
  logic                        seq;
  logic [vsd_pkg::CNT_W-1:0]   cnt_new;
  vsd_pkg::lane_res_t          res_nxt;
  logic                        valid_r;
  vsd_pkg::lane_res_t          res_r;

  always_comb begin
    grp       = byte_in[6:0];
    more      = byte_in[7];
    last_slot = carry_i.pb >= vsd_pkg::LAST_SLOT;
    sh        = 5'({2'b00, carry_i.pb} * 5'd7);
    if (last_slot) begin
      val  = carry_i.pv | {grp[3:0], 28'd0};
      over = more | (grp[6:4] != 3'd0);
    end else begin
      val  = carry_i.pv | ({25'd0, grp} << sh);
      over = 1'b0;
    end
    ends    = active & (~more | last_slot);
    cnt_new = carry_i.cnt + vsd_pkg::CNT_W'(ends);
    seq     = ends & hit_vec[cnt_new];

    // advance the carry to the next lane
    carry_o = carry_i;
    if (active) begin
      carry_o.cnt = cnt_new;
      if (ends) begin
        carry_o.pv = '0;
        carry_o.pb = '0;
      end else begin
        carry_o.pv = val;
        carry_o.pb = carry_i.pb + 3'd1;
      end
    end
    if (seq) begin
      carry_o.seen    = 1'b1;
      carry_o.last    = vsd_pkg::LANE_W'(LANE);
      carry_o.seq_cnt = cnt_new;
    end

    res_nxt.value        = val;
    res_nxt.sequence_end = seq;
    res_nxt.overlong     = over;
    if (!seq) begin
      res_nxt.bytes_used = '0;
    end else if (carry_i.seen) begin
      res_nxt.bytes_used = vsd_pkg::TOTAL_W'(vsd_pkg::LANE_W'(LANE) - carry_i.last);
    end else begin
      res_nxt.bytes_used = base + vsd_pkg::TOTAL_W'(LANE + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= ends;
    end else if (clear) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_nxt;
    end
  end

  assign valid_o = valid_r;
  assign res_o   = res_r;

endmodule
